### design/rskd_pkg.sv
// Shared types and constants for the small RSA key derivation block.
`timescale 1ns / 1ps
package rskd_pkg;
    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_PRIME,
        DIV_EUCLID
    } div_use_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic prime_start;
        logic prime_sel_q;
        logic euclid_start;
        logic out_load;
    } rskd_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic prime_done;
        logic euclid_done;
    } rskd_stat_t;
endpackage

### design/rskd_if.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
interface rskd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] prime_p;
    logic [15:0] prime_q;
    logic [15:0] public_exp;
    modport source (output valid, prime_p, prime_q, public_exp, input ready);
    modport sink (input valid, prime_p, prime_q, public_exp, output ready);
endinterface

interface rskd_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] modulus;
    logic [30:0] totient;
    logic        p_is_prime;
    logic        q_is_prime;
    logic        primes_differ;
    logic        exp_coprime;
    logic [30:0] private_exp;
    logic        key_valid;
    modport source (output valid, modulus, totient, p_is_prime, q_is_prime, primes_differ,
                    exp_coprime, private_exp, key_valid, input ready);
    modport sink (input valid, modulus, totient, p_is_prime, q_is_prime, primes_differ,
                  exp_coprime, private_exp, key_valid, output ready);
endinterface

### design/rsa_small_key_derive_top.sv
// Top level of the small RSA key derivation block.
`timescale 1ns / 1ps
// One key at a time: the block takes p, q and e, tests both candidates for
// primality by odd trial division up to the square root, then computes the
// inverse of e modulo (p-1)(q-1) with the extended Euclid algorithm. Every
// division runs on one shared radix-2 divider: one division per trial divisor
// (up to 127 per prime at 16 bits), one to reduce e modulo the totient and
// one per Euclid step. The next item is taken once the result has been
// delivered.
module rsa_small_key_derive_top #(
    parameter int PRIME_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rskd_in_if.sink    in_ch,
    rskd_out_if.source out_ch
);
    import rskd_pkg::*;

    rskd_cmd_t  cmd;
    rskd_stat_t stat;

    rskd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rskd_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_p          (in_ch.prime_p),
        .in_q          (in_ch.prime_q),
        .in_e          (in_ch.public_exp),
        .modulus       (out_ch.modulus),
        .totient       (out_ch.totient),
        .p_is_prime    (out_ch.p_is_prime),
        .q_is_prime    (out_ch.q_is_prime),
        .primes_differ (out_ch.primes_differ),
        .exp_coprime   (out_ch.exp_coprime),
        .private_exp   (out_ch.private_exp),
        .key_valid     (out_ch.key_valid)
    );
endmodule

### design/rskd_div.sv
// Shared restoring divider, one quotient bit per cycle, 32-bit operands.
`timescale 1ns / 1ps
module rskd_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quo_reg[31]} - {1'b0, dsr_reg};
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

### design/rskd_datapath.sv
// Datapath: operand registers, products, trial division and extended Euclid.
`timescale 1ns / 1ps
module rskd_datapath #(
    parameter int PRIME_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rskd_pkg::rskd_cmd_t  cmd,
    output rskd_pkg::rskd_stat_t stat,
    input  logic [15:0]          in_p,
    input  logic [15:0]          in_q,
    input  logic [15:0]          in_e,
    output logic [30:0]          modulus,
    output logic [30:0]          totient,
    output logic                 p_is_prime,
    output logic                 q_is_prime,
    output logic                 primes_differ,
    output logic                 exp_coprime,
    output logic [30:0]          private_exp,
    output logic                 key_valid
);
    import rskd_pkg::*;

    typedef enum logic [2:0] {
        PR_IDLE, PR_CHECK, PR_DIV, PR_WAIT
    } pr_state_t;
    typedef enum logic [2:0] {
        EU_IDLE, EU_MOD, EU_MODW, EU_TEST, EU_DIVW, EU_MUL, EU_FIX
    } eu_state_t;

    localparam logic [15:0] IN_MASK = 16'((32'd1 << PRIME_BITS) - 32'd1);

    logic [15:0] p_reg, q_reg, e_reg;
    logic [30:0] n_reg, z_reg;
    logic        mul_done_reg;
    logic        pp_reg, qp_reg;

    // prime test
    pr_state_t   pr_reg;
    logic [15:0] cand_reg;
    logic [15:0] k_reg;
    logic        sel_q_reg;
    logic        pr_done_reg;

    // euclid
    eu_state_t          eu_reg;
    logic [31:0]        r0_reg, r1_reg;
    logic signed [33:0] t0_reg, t1_reg;
    logic [31:0]        qt_reg;
    logic               cop_reg;
    logic [30:0]        d_reg;
    logic               eu_done_reg;

    // shared divider
    logic        div_start;
    logic [31:0] div_a, div_b;
    logic        div_done;
    logic [31:0] div_q, div_r;
    div_use_t    div_owner_reg;

    logic [15:0] pm, qm;
    logic [31:0] kk;
    logic signed [33:0] t_new;
    logic signed [67:0] prod;

    assign pm   = (p_reg == 16'd0) ? 16'd0 : p_reg - 16'd1;
    assign qm   = (q_reg == 16'd0) ? 16'd0 : q_reg - 16'd1;
    assign kk   = {16'd0, k_reg} * {16'd0, k_reg};
    assign prod = $signed({2'b00, qt_reg}) * t1_reg;
    assign t_new = t0_reg - prod[33:0];

    rskd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        if (pr_reg == PR_CHECK && cand_reg > 16'd2 && cand_reg[0] && kk <= {16'd0, cand_reg})
        begin
            div_start = 1'b1;
            div_a     = {16'd0, cand_reg};
            div_b     = {16'd0, k_reg};
        end
        else if (eu_reg == EU_MOD)
        begin
            div_start = 1'b1;
            div_a     = {16'd0, e_reg};
            div_b     = {1'b0, z_reg};
        end
        else if (eu_reg == EU_TEST && r1_reg != 32'd0)
        begin
            div_start = 1'b1;
            div_a     = r0_reg;
            div_b     = r1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_reg        <= PR_IDLE;
            eu_reg        <= EU_IDLE;
            mul_done_reg  <= 1'b0;
            pr_done_reg   <= 1'b0;
            eu_done_reg   <= 1'b0;
            div_owner_reg <= DIV_NONE;
        end
        else
        begin
            mul_done_reg <= cmd.mul_start;
            pr_done_reg  <= 1'b0;
            eu_done_reg  <= 1'b0;
            if (div_start)
            begin
                div_owner_reg <= (pr_reg == PR_CHECK) ? DIV_PRIME : DIV_EUCLID;
            end

            unique case (pr_reg)
                PR_IDLE:
                begin
                    if (cmd.prime_start)
                    begin
                        pr_reg <= PR_CHECK;
                    end
                end
                PR_CHECK:
                begin
                    if (div_start)
                    begin
                        pr_reg <= PR_DIV;
                    end
                    else
                    begin
                        pr_reg      <= PR_WAIT;
                        pr_done_reg <= 1'b1;
                    end
                end
                PR_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_r == 32'd0)
                        begin
                            pr_reg      <= PR_WAIT;
                            pr_done_reg <= 1'b1;
                        end
                        else
                        begin
                            pr_reg <= PR_CHECK;
                        end
                    end
                end
                PR_WAIT:
                begin
                    pr_reg <= PR_IDLE;
                end
                default:
                begin
                    pr_reg <= PR_IDLE;
                end
            endcase

            unique case (eu_reg)
                EU_IDLE:
                begin
                    if (cmd.euclid_start)
                    begin
                        if (z_reg < 31'd2)
                        begin
                            eu_done_reg <= 1'b1;
                        end
                        else
                        begin
                            eu_reg <= EU_MOD;
                        end
                    end
                end
                EU_MOD:  eu_reg <= EU_MODW;
                EU_MODW:
                begin
                    if (div_done)
                    begin
                        eu_reg <= EU_TEST;
                    end
                end
                EU_TEST:
                begin
                    if (r1_reg == 32'd0)
                    begin
                        if (r0_reg == 32'd1)
                        begin
                            eu_reg <= EU_FIX;
                        end
                        else
                        begin
                            eu_reg      <= EU_IDLE;
                            eu_done_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        eu_reg <= EU_DIVW;
                    end
                end
                EU_DIVW:
                begin
                    if (div_done)
                    begin
                        eu_reg <= EU_MUL;
                    end
                end
                EU_MUL:  eu_reg <= EU_TEST;
                EU_FIX:
                begin
                    eu_reg      <= EU_IDLE;
                    eu_done_reg <= 1'b1;
                end
                default: eu_reg <= EU_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg <= in_p & IN_MASK;
            q_reg <= in_q & IN_MASK;
            e_reg <= in_e & IN_MASK;
        end
        if (cmd.mul_start)
        begin
            n_reg <= 31'({16'd0, p_reg} * {16'd0, q_reg});
            z_reg <= 31'({16'd0, pm} * {16'd0, qm});
        end

        if (pr_reg == PR_IDLE && cmd.prime_start)
        begin
            cand_reg  <= cmd.prime_sel_q ? q_reg : p_reg;
            sel_q_reg <= cmd.prime_sel_q;
            k_reg     <= 16'd3;
        end
        else if (pr_reg == PR_CHECK && !div_start)
        begin
            if (sel_q_reg)
            begin
                qp_reg <= (cand_reg == 16'd2) || (cand_reg > 16'd2 && cand_reg[0]);
            end
            else
            begin
                pp_reg <= (cand_reg == 16'd2) || (cand_reg > 16'd2 && cand_reg[0]);
            end
        end
        else if (pr_reg == PR_DIV && div_done && div_owner_reg == DIV_PRIME)
        begin
            if (div_r == 32'd0)
            begin
                if (sel_q_reg)
                begin
                    qp_reg <= 1'b0;
                end
                else
                begin
                    pp_reg <= 1'b0;
                end
            end
            k_reg <= k_reg + 16'd2;
        end

        if (eu_reg == EU_IDLE && cmd.euclid_start)
        begin
            cop_reg <= 1'b0;
            d_reg   <= '0;
            r0_reg  <= {1'b0, z_reg};
            t0_reg  <= '0;
            t1_reg  <= 34'sd1;
        end
        else if (eu_reg == EU_MODW && div_done)
        begin
            r1_reg <= div_r;
        end
        else if (eu_reg == EU_DIVW && div_done)
        begin
            qt_reg <= div_q;
            r0_reg <= r1_reg;
            r1_reg <= div_r;
        end
        else if (eu_reg == EU_MUL)
        begin
            t0_reg <= t1_reg;
            t1_reg <= t_new;
        end
        else if (eu_reg == EU_FIX)
        begin
            cop_reg <= 1'b1;
            d_reg   <= t0_reg[33] ? 31'(t0_reg + $signed({3'b000, z_reg})) : t0_reg[30:0];
        end

        if (cmd.out_load)
        begin
            modulus       <= n_reg;
            totient       <= z_reg;
            p_is_prime    <= pp_reg;
            q_is_prime    <= qp_reg;
            primes_differ <= (p_reg != q_reg);
            exp_coprime   <= cop_reg;
            private_exp   <= d_reg;
            key_valid     <= pp_reg && qp_reg && (p_reg != q_reg) && cop_reg;
        end
    end

    assign stat.mul_done    = mul_done_reg;
    assign stat.prime_done  = pr_done_reg;
    assign stat.euclid_done = eu_done_reg;
endmodule

### design/rskd_ctrl.sv
// Controller: sequences load, products, prime tests, inverse and result hand-off.
`timescale 1ns / 1ps
module rskd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rskd_pkg::rskd_cmd_t  cmd,
    input  rskd_pkg::rskd_stat_t stat
);
    import rskd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MULW, S_PP, S_PPW, S_QP, S_QPW, S_EU, S_EUW, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load         = (state_reg == S_IDLE) && in_valid;
        cmd.mul_start    = (state_reg == S_MUL);
        cmd.prime_start  = (state_reg == S_PP) || (state_reg == S_QP);
        cmd.prime_sel_q  = (state_reg == S_QP);
        cmd.euclid_start = (state_reg == S_EU);
        cmd.out_load     = (state_reg == S_EUW) && stat.euclid_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_valid) state_reg <= S_MUL;
                S_MUL:  state_reg <= S_MULW;
                S_MULW: if (stat.mul_done) state_reg <= S_PP;
                S_PP:   state_reg <= S_PPW;
                S_PPW:  if (stat.prime_done) state_reg <= S_QP;
                S_QP:   state_reg <= S_QPW;
                S_QPW:  if (stat.prime_done) state_reg <= S_EU;
                S_EU:   state_reg <= S_EUW;
                S_EUW:
                begin
                    if (stat.euclid_done)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

### tb/sv/rsa_small_key_derive_top_test.sv
// Testbench for the small RSA key derivation block: directed table and random keys.
`timescale 1ns / 1ps
module rsa_small_key_derive_top_test;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int N_RANDOM     = 104;
    localparam int N_DIRECTED   = 16;

    typedef struct packed {
        logic [30:0] modulus;
        logic [30:0] totient;
        logic        p_is_prime;
        logic        q_is_prime;
        logic        primes_differ;
        logic        exp_coprime;
        logic [30:0] private_exp;
        logic        key_valid;
    } key_t;

    typedef struct {
        logic [15:0] p;
        logic [15:0] q;
        logic [15:0] e;
        bit          typed;
        key_t        key;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   errors = 0;
    int   sent = 0;
    int   got = 0;
    int   n_valid = 0;
    bit   no_idle = 1'b0;
    key_t expected_keys[$];
    row_t table_rows[N_DIRECTED];

    rskd_in_if  in_ch ();
    rskd_out_if out_ch ();

    rsa_small_key_derive_top #(.PRIME_BITS(16)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit prime_test(logic [15:0] a);
        int unsigned k;
        if (a < 2) return 1'b0;
        if (a == 2) return 1'b1;
        if (a[0] == 1'b0) return 1'b0;
        for (k = 3; k * k <= a; k += 2)
            if (a % k == 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic key_t derive_key(logic [15:0] p, logic [15:0] q, logic [15:0] e);
        key_t k;
        longint pm;
        longint qm;
        longint zl;
        longint r0;
        longint r1;
        longint t0;
        longint t1;
        longint quo;
        longint tmp;
        pm = (p == 0) ? 0 : longint'(p) - 1;
        qm = (q == 0) ? 0 : longint'(q) - 1;
        k.modulus       = 31'((longint'(p) * longint'(q)) & 64'h7FFF_FFFF);
        zl              = (pm * qm) & 64'h7FFF_FFFF;
        k.totient       = 31'(zl);
        k.p_is_prime    = prime_test(p);
        k.q_is_prime    = prime_test(q);
        k.primes_differ = (p != q);
        k.exp_coprime   = 1'b0;
        k.private_exp   = '0;
        if (zl >= 2)
        begin
            r0 = zl;
            r1 = longint'(e) % zl;
            t0 = 0;
            t1 = 1;
            while (r1 != 0)
            begin
                quo = r0 / r1;
                tmp = r0 - quo * r1; r0 = r1; r1 = tmp;
                tmp = t0 - quo * t1; t0 = t1; t1 = tmp;
            end
            if (r0 == 1)
            begin
                t0 = t0 % zl;
                if (t0 < 0) t0 += zl;
                k.exp_coprime = 1'b1;
                k.private_exp = 31'(t0);
            end
        end
        k.key_valid = k.p_is_prime & k.q_is_prime & k.primes_differ & k.exp_coprime;
        return k;
    endfunction

    task automatic report_mismatch(string what, longint unsigned seen, longint unsigned want);
        $display("mismatch item %0d %s: got %0d want %0d", got, what, seen, want);
        errors++;
    endtask

    function automatic logic [15:0] pick_prime();
        logic [15:0] v;
        do v = 16'($urandom_range(2, 46339)); while (!prime_test(v));
        return v;
    endfunction

    function automatic logic [15:0] pick_small_prime();
        logic [15:0] v;
        do v = 16'($urandom_range(2, 400)); while (!prime_test(v));
        return v;
    endfunction

    task automatic send_key(logic [15:0] p, logic [15:0] q, logic [15:0] e);
        @(posedge clk);
        while (!no_idle && $urandom_range(0, 99) < 35)
            @(posedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.prime_p    <= p;
        in_ch.prime_q    <= q;
        in_ch.public_exp <= e;
        expected_keys.push_back(derive_key(p, q, e));
        do @(posedge clk); while (!in_ch.ready);
        in_ch.valid <= 1'b0;
        sent++;
    endtask

    task automatic set_row(int i, logic [15:0] p, logic [15:0] q, logic [15:0] e, bit typed,
                           key_t k);
        table_rows[i] = '{p, q, e, typed, k};
    endtask

    always @(posedge clk)
    begin
        key_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_keys.size() == 0)
                begin
                    $display("unexpected result item");
                    errors++;
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (out_ch.modulus != want.modulus)
                        report_mismatch("modulus", out_ch.modulus, want.modulus);
                    if (out_ch.totient != want.totient)
                        report_mismatch("totient", out_ch.totient, want.totient);
                    if (out_ch.p_is_prime != want.p_is_prime)
                        report_mismatch("p_is_prime", out_ch.p_is_prime, want.p_is_prime);
                    if (out_ch.q_is_prime != want.q_is_prime)
                        report_mismatch("q_is_prime", out_ch.q_is_prime, want.q_is_prime);
                    if (out_ch.primes_differ != want.primes_differ)
                        report_mismatch("primes_differ", out_ch.primes_differ,
                                        want.primes_differ);
                    if (out_ch.exp_coprime != want.exp_coprime)
                        report_mismatch("exp_coprime", out_ch.exp_coprime, want.exp_coprime);
                    if (out_ch.private_exp != want.private_exp)
                        report_mismatch("private_exp", out_ch.private_exp, want.private_exp);
                    if (out_ch.key_valid != want.key_valid)
                        report_mismatch("key_valid", out_ch.key_valid, want.key_valid);
                    n_valid += want.key_valid;
                end
                got++;
            end
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 35);
        end
    end

    initial
    begin
        int i;
        logic [15:0] p;
        logic [15:0] q;
        logic [15:0] e;
        int wait_cnt;
        in_ch.valid      = 1'b0;
        in_ch.prime_p    = '0;
        in_ch.prime_q    = '0;
        in_ch.public_exp = '0;
        set_row(0, 16'd0, 16'd0, 16'd0, 1, '{0, 0, 0, 0, 0, 0, 0, 0});
        set_row(1, 16'd1, 16'd1, 16'd1, 1, '{1, 0, 0, 0, 0, 0, 0, 0});
        set_row(2, 16'd2, 16'd2, 16'd1, 1, '{4, 1, 1, 1, 0, 0, 0, 0});
        set_row(3, 16'd2, 16'd3, 16'd1, 1, '{6, 2, 1, 1, 1, 1, 1, 1});
        set_row(4, 16'd3, 16'd5, 16'd3, 1, '{15, 8, 1, 1, 1, 1, 3, 1});
        set_row(5, 16'd3, 16'd5, 16'd0, 1, '{15, 8, 1, 1, 1, 0, 0, 0});
        set_row(6, 16'd3, 16'd5, 16'd2, 1, '{15, 8, 1, 1, 1, 0, 0, 0});
        set_row(7, 16'd0, 16'd7, 16'd5, 1, '{0, 0, 0, 1, 1, 0, 0, 0});
        set_row(8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0);
        set_row(9, 16'hFFF1, 16'hFFFB, 16'd65535, 0, '0);
        set_row(10, 16'd46337, 16'd46327, 16'd65535, 0, '0);
        set_row(11, 16'd61, 16'd53, 16'd17, 0, '0);
        set_row(12, 16'd9, 16'd15, 16'd7, 0, '0);
        set_row(13, 16'd65521, 16'd2, 16'd3, 0, '0);
        set_row(14, 16'hAAAA, 16'h5555, 16'h8001, 0, '0);
        set_row(15, 16'd101, 16'd103, 16'd65535, 0, '0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < N_DIRECTED; i++)
        begin
            send_key(table_rows[i].p, table_rows[i].q, table_rows[i].e);
            if (table_rows[i].typed && derive_key(table_rows[i].p, table_rows[i].q,
                                                  table_rows[i].e) != table_rows[i].key)
            begin
                $display("directed row %0d disagrees with table", i);
                errors++;
            end
        end
        while (expected_keys.size() != 0)
            @(posedge clk);
        for (i = 0; i < N_RANDOM; i++)
        begin
            no_idle <= (i >= 40 && i < 60);
            case ($urandom_range(0, 9))
                0: begin p = 16'($urandom); q = 16'($urandom); end
                1: begin p = pick_prime(); q = p; end
                2, 3: begin p = pick_small_prime(); q = pick_small_prime(); end
                default: begin p = pick_prime(); q = pick_prime(); end
            endcase
            e = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
            send_key(p, q, e);
            if (i == 80)
                while (expected_keys.size() != 0)
                    @(posedge clk);
        end
        no_idle <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
        wait_cnt = 0;
        while (wait_cnt < 200)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        $display("ran %0d keys (%0d valid) incl. zero, one, equal, wide and non-coprime cases",
                 got, n_valid);
        if (errors == 0 && got == sent)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

### rsa_small_key_derive_top.f
design/rskd_pkg.sv
design/rskd_if.sv
design/rskd_div.sv
design/rskd_datapath.sv
design/rskd_ctrl.sv
design/rsa_small_key_derive_top.sv
tb/sv/rsa_small_key_derive_top_test.sv
